/* hw/rtl/iambic_cw_keyer_top_assert.svh */
// ----------------------------------------------------------------------------
// Iambic CW keyer assertion macros
// Clocked concurrent assertions, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef IAMBIC_CW_KEYER_TOP_ASSERT_SVH
`define IAMBIC_CW_KEYER_TOP_ASSERT_SVH
`ifndef SYNTH
// Assertion disabled while reset is high
`define ICK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Assertion checked at every edge, reset included
`define ICK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ICK_ASSERT(label, clk, rst, prop, msg)
`define ICK_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* hw/rtl/ick_pkg.sv */
// ----------------------------------------------------------------------------
// ick_pkg
// Shared types, register codes and the speed table of the iambic CW keyer.
// ----------------------------------------------------------------------------
`default_nettype none

package ick_pkg;

  // One poll of the paddles
  typedef struct packed {
    logic [31:0] time_ms;
    logic        dit_paddle;
    logic        dah_paddle;
  } ick_in_t;

  // One keyer result
  typedef struct packed {
    logic key_out;
    logic transmit_out;
  } ick_out_t;

  // Register indexes
  localparam logic [2:0] REG_KEYER_MODE   = 3'd0;
  localparam logic [2:0] REG_WPM          = 3'd1;
  localparam logic [2:0] REG_SWAP_PADDLES = 3'd2;
  localparam logic [2:0] REG_BREAKIN_MODE = 3'd3;
  localparam logic [2:0] REG_HANG_DELAY   = 3'd4;

  localparam int unsigned ADDR_W = 5;

  // Keyer modes
  localparam logic [1:0] MODE_STRAIGHT = 2'd0;
  localparam logic [1:0] MODE_IAMBIC_A = 2'd1;
  localparam logic [1:0] MODE_IAMBIC_B = 2'd2;

  // Break-in modes
  localparam logic [1:0] BREAKIN_OFF  = 2'd0;
  localparam logic [1:0] BREAKIN_SEMI = 2'd1;
  localparam logic [1:0] BREAKIN_FULL = 2'd2;

  // Speed limits and reset values
  localparam logic [5:0]  WPM_MIN       = 6'd5;
  localparam logic [5:0]  WPM_MAX       = 6'd40;
  localparam logic [5:0]  WPM_RESET     = 6'd20;
  localparam logic [7:0]  DIT_LEN_RESET = 8'd60;
  localparam logic [15:0] HANG_RESET    = 16'd300;

  // Settings seen by the keyer core
  typedef struct packed {
    logic [1:0]  keyer_mode;
    logic        swap_paddles;
    logic [1:0]  breakin_mode;
    logic [15:0] hang_delay_ms;
    logic [7:0]  dit_len;
    logic [9:0]  dah_len;
  } ick_cfg_t;

  // Dit length in ms: 1200 / wpm, truncated, for wpm in 5..40
  function automatic logic [7:0] dit_len_of(input logic [5:0] wpm);
    logic [7:0] len;
    case (wpm)
      6'd5:    len = 8'd240;
      6'd6:    len = 8'd200;
      6'd7:    len = 8'd171;
      6'd8:    len = 8'd150;
      6'd9:    len = 8'd133;
      6'd10:   len = 8'd120;
      6'd11:   len = 8'd109;
      6'd12:   len = 8'd100;
      6'd13:   len = 8'd92;
      6'd14:   len = 8'd85;
      6'd15:   len = 8'd80;
      6'd16:   len = 8'd75;
      6'd17:   len = 8'd70;
      6'd18:   len = 8'd66;
      6'd19:   len = 8'd63;
      6'd20:   len = 8'd60;
      6'd21:   len = 8'd57;
      6'd22:   len = 8'd54;
      6'd23:   len = 8'd52;
      6'd24:   len = 8'd50;
      6'd25:   len = 8'd48;
      6'd26:   len = 8'd46;
      6'd27:   len = 8'd44;
      6'd28:   len = 8'd42;
      6'd29:   len = 8'd41;
      6'd30:   len = 8'd40;
      6'd31:   len = 8'd38;
      6'd32:   len = 8'd37;
      6'd33:   len = 8'd36;
      6'd34:   len = 8'd35;
      6'd35:   len = 8'd34;
      6'd36:   len = 8'd33;
      6'd37:   len = 8'd32;
      6'd38:   len = 8'd31;
      6'd39:   len = 8'd30;
      default: len = 8'd30;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/ick_cfg.sv */
// ----------------------------------------------------------------------------
// ick_cfg
// APB register file: mode, speed, paddle swap, break-in mode and hang delay.
// Speed writes are clamped and turned into dit and dah lengths.
// ----------------------------------------------------------------------------
`default_nettype none

module ick_cfg
  import ick_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output ick_cfg_t               cfg
);

  logic [5:0] wpm;
  logic [5:0] wpm_clamped;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  // clamp speed to the supported range
  always_comb begin
    wpm_clamped = pwdata[5:0];
    if (pwdata[5:0] < WPM_MIN) begin
      wpm_clamped = WPM_MIN;
    end else if (pwdata[5:0] > WPM_MAX) begin
      wpm_clamped = WPM_MAX;
    end
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.keyer_mode    <= MODE_IAMBIC_A;
      wpm               <= WPM_RESET;
      cfg.swap_paddles  <= 1'b0;
      cfg.breakin_mode  <= BREAKIN_OFF;
      cfg.hang_delay_ms <= HANG_RESET;
      cfg.dit_len       <= DIT_LEN_RESET;
      cfg.dah_len       <= 10'(DIT_LEN_RESET) * 10'd3;
    end else if (wr_en) begin
      case (reg_idx)
        REG_KEYER_MODE:   cfg.keyer_mode    <= pwdata[1:0];
        REG_WPM: begin
          wpm         <= wpm_clamped;
          cfg.dit_len <= dit_len_of(wpm_clamped);
          cfg.dah_len <= 10'(dit_len_of(wpm_clamped)) * 10'd3;
        end
        REG_SWAP_PADDLES: cfg.swap_paddles  <= pwdata[0];
        REG_BREAKIN_MODE: cfg.breakin_mode  <= pwdata[1:0];
        REG_HANG_DELAY:   cfg.hang_delay_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_KEYER_MODE:   prdata = {30'd0, cfg.keyer_mode};
      REG_WPM:          prdata = {26'd0, wpm};
      REG_SWAP_PADDLES: prdata = {31'd0, cfg.swap_paddles};
      REG_BREAKIN_MODE: prdata = {30'd0, cfg.breakin_mode};
      REG_HANG_DELAY:   prdata = {16'd0, cfg.hang_delay_ms};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/ick_core.sv */
// ----------------------------------------------------------------------------
// ick_core
// Keyer state: straight / iambic element sequencer and break-in control.
// Next outputs are combinational from the staged poll; state updates on en.
// ----------------------------------------------------------------------------
`default_nettype none

module ick_core
  import ick_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     en,
  input  wire ick_in_t  poll,
  input  wire ick_cfg_t cfg,
  output ick_out_t      result
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DIT  = 2'd1,
    PH_DAH  = 2'd2,
    PH_GAP  = 2'd3
  } phase_t;

  phase_t      phase, phase_next;
  logic        key_level, key_level_next;
  logic        transmit_level, transmit_level_next;
  logic        dit_memory, dit_memory_next;
  logic        dah_memory, dah_memory_next;
  logic        last_was_dit, last_was_dit_next;
  logic        hang_armed, hang_armed_next;
  logic [31:0] element_start, element_start_next;
  logic [31:0] last_release, last_release_next;

  logic        dit, dah, mode_b, active;
  logic [31:0] now, elapsed, since_release;
  logic        el_ge_dit, el_ge_dah;

  assign now       = poll.time_ms;
  assign dit       = cfg.swap_paddles ? poll.dah_paddle : poll.dit_paddle;
  assign dah       = cfg.swap_paddles ? poll.dit_paddle : poll.dah_paddle;
  assign mode_b    = (cfg.keyer_mode == MODE_IAMBIC_B);
  assign elapsed   = now - element_start;
  assign el_ge_dit = (elapsed >= {24'd0, cfg.dit_len});
  assign el_ge_dah = (elapsed >= {22'd0, cfg.dah_len});

  // keyer and break-in next state
  always_comb begin
    phase_next          = phase;
    key_level_next      = key_level;
    transmit_level_next = transmit_level;
    dit_memory_next     = dit_memory;
    dah_memory_next     = dah_memory;
    last_was_dit_next   = last_was_dit;
    hang_armed_next     = hang_armed;
    element_start_next  = element_start;
    last_release_next   = last_release;
    active              = 1'b0;

    if (cfg.keyer_mode == MODE_STRAIGHT) begin
      // straight key follows either paddle
      active         = dit || dah;
      key_level_next = dit || dah;
      if (key_level && !(dit || dah)) begin
        last_release_next = now;
      end
    end else begin
      case (phase)
        PH_IDLE: begin
          key_level_next  = 1'b0;
          dit_memory_next = 1'b0;
          dah_memory_next = 1'b0;
          if (dit) begin
            phase_next = PH_DIT; element_start_next = now; key_level_next = 1'b1;
          end else if (dah) begin
            phase_next = PH_DAH; element_start_next = now; key_level_next = 1'b1;
          end
        end
        PH_DIT: begin
          key_level_next = 1'b1;
          if (mode_b && dah) dah_memory_next = 1'b1;
          if (el_ge_dit) begin
            key_level_next     = 1'b0;
            last_was_dit_next  = 1'b1;
            last_release_next  = now;
            phase_next         = PH_GAP;
            element_start_next = now;
          end
        end
        PH_DAH: begin
          key_level_next = 1'b1;
          if (mode_b && dit) dit_memory_next = 1'b1;
          if (el_ge_dah) begin
            key_level_next     = 1'b0;
            last_was_dit_next  = 1'b0;
            last_release_next  = now;
            phase_next         = PH_GAP;
            element_start_next = now;
          end
        end
        PH_GAP: begin
          key_level_next = 1'b0;
          if (el_ge_dit) begin
            // alternate: prefer the opposite element
            if (last_was_dit) begin
              dah_memory_next = 1'b0;
              if (dah || dah_memory) begin
                phase_next = PH_DAH; element_start_next = now; key_level_next = 1'b1;
              end else if (dit) begin
                phase_next = PH_DIT; element_start_next = now; key_level_next = 1'b1;
              end else begin
                phase_next = PH_IDLE;
              end
            end else begin
              dit_memory_next = 1'b0;
              if (dit || dit_memory) begin
                phase_next = PH_DIT; element_start_next = now; key_level_next = 1'b1;
              end else if (dah) begin
                phase_next = PH_DAH; element_start_next = now; key_level_next = 1'b1;
              end else begin
                phase_next = PH_IDLE;
              end
            end
          end
        end
        default: ;
      endcase
      active = (phase_next != PH_IDLE);
    end

    // break-in transmit control
    since_release = now - last_release_next;
    case (cfg.breakin_mode)
      BREAKIN_OFF: transmit_level_next = 1'b0;
      BREAKIN_SEMI: begin
        if (active) begin
          transmit_level_next = 1'b1;
          hang_armed_next     = 1'b1;
          last_release_next   = now;
        end else if (hang_armed && (since_release >= {16'd0, cfg.hang_delay_ms})) begin
          transmit_level_next = 1'b0;
          hang_armed_next     = 1'b0;
        end
      end
      BREAKIN_FULL: begin
        if (active) begin
          transmit_level_next = 1'b1;
          last_release_next   = now;
        end else if (transmit_level && (since_release >= {24'd0, cfg.dit_len})) begin
          transmit_level_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign result.key_out      = key_level_next;
  assign result.transmit_out = transmit_level_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      key_level      <= 1'b0;
      transmit_level <= 1'b0;
      dit_memory     <= 1'b0;
      dah_memory     <= 1'b0;
      last_was_dit   <= 1'b0;
      hang_armed     <= 1'b0;
      element_start  <= 32'd0;
      last_release   <= 32'd0;
    end else if (en) begin
      phase          <= phase_next;
      key_level      <= key_level_next;
      transmit_level <= transmit_level_next;
      dit_memory     <= dit_memory_next;
      dah_memory     <= dah_memory_next;
      last_was_dit   <= last_was_dit_next;
      hang_armed     <= hang_armed_next;
      element_start  <= element_start_next;
      last_release   <= last_release_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/iambic_cw_keyer_top.sv */
// ----------------------------------------------------------------------------
// iambic_cw_keyer_top
// Iambic / straight CW keyer with break-in transmit control.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, in_data) carries one paddle poll per
//   transaction: a millisecond timestamp and the dit and dah levels.
//   Output channel (out_valid, out_stall, out_data) returns exactly one
//   result per poll: key_out and transmit_out after that poll.
//   From input acceptance the poll waits in the input register, then passes
//   through the keyer logic into the result register.
//   Throughput is one poll per cycle while the receiver does not stall; the
//   keyer state loop closes through the core's compare and select logic.
//   When the receiver stalls, the result register holds its transaction and
//   the input register fills; in_stall rises only once both are occupied.
//   Reset (rst, synchronous) empties both registers, returns the keyer to
//   idle with key and transmit low, and loads register defaults (iambic A,
//   20 wpm, no swap, break-in off, 300 ms hang). The user must write registers
//   over the APB port while no poll is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "iambic_cw_keyer_top_assert.svh"

module iambic_cw_keyer_top
  import ick_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ick_in_t           in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ick_out_t               out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  ick_cfg_t cfg;
  ick_in_t  s1_data;
  ick_out_t core_result;
  logic     s1_valid;
  logic     advance;
  logic     in_take;

  // stage handshake
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  ick_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ick_core u_core (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .poll   (s1_data),
    .cfg    (cfg),
    .result (core_result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= core_result;
    end
  end

  // checks
  `ICK_ASSERT(a_stall_only_full, clk, rst, in_stall |-> s1_valid, "stall with empty input register")
  `ICK_ASSERT(a_held_poll_kept, clk, rst, (s1_valid && !advance) |=> s1_valid, "held poll dropped")
  `ICK_ASSERT(a_result_from_poll, clk, rst, $rose(out_valid) |-> $past(s1_valid), "result without poll")
  `ICK_ASSERT(a_dah_three_dits, clk, rst, cfg.dah_len == 10'(cfg.dit_len) * 10'd3, "dah length mismatch")

endmodule

`default_nettype wire
